// ===== rtl/sbrp_pkg.sv =====
package sbrp_pkg;

  localparam int unsigned MaxDatagramBytesDef = 2048;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PortW   = 16;
  localparam int unsigned IpW     = 32;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  localparam logic [31:0] MagicCookie    = 32'h2112_A442;
  localparam logic [15:0] BindingSuccess = 16'h0101;
  localparam logic [7:0]  FamilyIpv4     = 8'h01;
  localparam logic [15:0] AttrMapped     = 16'h0001;
  localparam logic [15:0] MappedLen      = 16'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTxidHigh = 1'b0,
    CfgTxidLow  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StNotBinding = 3'd1,
    StBadCookie  = 3'd2,
    StIdMismatch = 3'd3,
    StBadLength  = 3'd4,
    StNotIpv4    = 3'd5,
    StTruncated  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhAttrHdr = 2'd1,
    PhMapped  = 2'd2,
    PhSkip    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [PortW-1:0] port;
    logic [IpW-1:0]   ip;
  } verdict_t;

endpackage

// ===== rtl/sbrp_in_reg.sv =====
module sbrp_in_reg import sbrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_beat_t beat_i,
  output logic     valid_o,
  output in_beat_t beat_o,
  input  logic     take_i
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/sbrp_parse_core.sv =====
module sbrp_parse_core import sbrp_pkg::*; #(
  parameter int unsigned MaxDatagramBytes = MaxDatagramBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_beat_t    beat_i,
  input  logic [31:0] txid_high_i,
  input  logic [63:0] txid_low_i,
  output logic        done_o,
  output verdict_t    verdict_o
);

  localparam int unsigned CntW = $clog2(MaxDatagramBytes + 1);

  typedef struct packed {
    phase_e           phase;
    logic [4:0]       pos;
    logic [CntW-1:0]  total;
    logic [15:0]      atype;
    logic [15:0]      alen;
    logic [16:0]      skip;
    status_e          err;
    logic             found;
    logic [PortW-1:0] port;
    logic [IpW-1:0]   ip;
  } core_st_t;

  localparam core_st_t StClear = '{
    phase: PhHeader, pos: '0, total: '0, atype: '0, alen: '0, skip: '0,
    err: StOk, found: 1'b0, port: '0, ip: '0
  };

  core_st_t st_q, st_d, st_u;

  logic [95:0] txid;
  logic [3:0]  id_idx;
  logic [7:0]  id_byte;
  logic [7:0]  b;
  logic [15:0] len_new;
  logic [1:0]  pad;
  logic [16:0] skip_new;
  logic        trunc;
  status_e     status;

  assign txid    = {txid_high_i, txid_low_i};
  assign id_idx  = 4'(st_q.pos - 5'd8);
  assign b       = beat_i.data;
  assign len_new = {st_q.alen[7:0], b};
  // padding up to a 4-byte boundary
  assign pad      = ~len_new[1:0] + 2'd1;
  assign skip_new = 17'(len_new) + 17'(pad);

  always_comb begin
    id_byte = '0;
    for (int k = 0; k < 12; k++) begin
      if (id_idx == 4'(k)) begin
        id_byte = txid[8*(11-k) +: 8];
      end
    end
  end

  // state after taking one byte
  always_comb begin
    st_u = st_q;
    if (st_q.total < CntW'(MaxDatagramBytes)) begin
      st_u.total = st_q.total + 1'b1;
      if (st_q.err == StOk) begin
        st_u.pos = st_q.pos + 5'd1;
        case (st_q.phase)
          PhHeader: begin
            if (st_q.pos < 5'd2) begin
              st_u.atype = {st_q.atype[7:0], b};
              if (st_q.pos == 5'd1 && {st_q.atype[7:0], b} != BindingSuccess) begin
                st_u.err = StNotBinding;
              end
            end else if (st_q.pos inside {[5'd4:5'd7]}) begin
              st_u.ip = {st_q.ip[23:0], b};
              if (st_q.pos == 5'd7) begin
                if ({st_q.ip[23:0], b} != MagicCookie) begin
                  st_u.err = StBadCookie;
                end
                st_u.ip = '0;
              end
            end else if (st_q.pos inside {[5'd8:5'd19]}) begin
              if (b != id_byte) begin
                st_u.err = StIdMismatch;
              end
            end
            if (st_q.pos == 5'd19) begin
              st_u.phase = PhAttrHdr;
              st_u.pos   = '0;
              st_u.atype = '0;
              st_u.alen  = '0;
            end
          end
          PhAttrHdr: begin
            if (st_q.pos < 5'd2) begin
              st_u.atype = {st_q.atype[7:0], b};
            end else begin
              st_u.alen = len_new;
            end
            if (st_q.pos == 5'd3) begin
              if (st_q.atype == AttrMapped) begin
                if (len_new != MappedLen) begin
                  st_u.err = StBadLength;
                end else begin
                  st_u.phase = PhMapped;
                  st_u.pos   = '0;
                end
              end else begin
                st_u.skip = skip_new;
                if (skip_new == '0) begin
                  st_u.phase = PhAttrHdr;
                  st_u.pos   = '0;
                  st_u.atype = '0;
                  st_u.alen  = '0;
                end else begin
                  st_u.phase = PhSkip;
                  st_u.pos   = '0;
                end
              end
            end
          end
          PhMapped: begin
            if (st_q.pos == 5'd1) begin
              if (b != FamilyIpv4) begin
                st_u.err = StNotIpv4;
              end
            end else if (st_q.pos == 5'd2 || st_q.pos == 5'd3) begin
              st_u.port = {st_q.port[7:0], b};
            end else if (st_q.pos >= 5'd4) begin
              st_u.ip = {st_q.ip[23:0], b};
            end
            if (st_q.pos >= 5'd7) begin
              st_u.found = 1'b1;
              st_u.phase = PhAttrHdr;
              st_u.pos   = '0;
              st_u.atype = '0;
              st_u.alen  = '0;
            end
          end
          default: begin
            st_u.pos = st_q.pos;
            if (st_q.skip != '0) begin
              st_u.skip = st_q.skip - 17'd1;
            end
            if (st_u.skip == '0) begin
              st_u.phase = PhAttrHdr;
              st_u.pos   = '0;
              st_u.atype = '0;
              st_u.alen  = '0;
            end
          end
        endcase
      end
    end
  end

  assign trunc = st_u.phase == PhHeader || st_u.phase == PhMapped ||
                 (st_u.phase == PhAttrHdr && st_u.pos != '0);

  always_comb begin
    if (st_u.err != StOk) begin
      status = st_u.err;
    end else if (trunc) begin
      status = StTruncated;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    verdict_o = '{status: status, found: 1'b0, port: '0, ip: '0};
    if (status == StOk && st_u.found) begin
      verdict_o.found = 1'b1;
      verdict_o.port  = st_u.port;
      verdict_o.ip    = st_u.ip;
    end
  end

  assign done_o = step_i && beat_i.last;

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = beat_i.last ? StClear : st_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ===== rtl/sbrp_out_reg.sv =====
module sbrp_out_reg import sbrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  verdict_t            verdict_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutDataW-1:0] data_o
);

  logic     valid_q, valid_d;
  verdict_t verdict_q;

  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = {4'b0, verdict_q.ip, verdict_q.port, verdict_q.found, verdict_q.status};

endmodule

// ===== rtl/stun_binding_response_parser.sv =====
// Parses a received STUN binding success response, one datagram byte per transaction on the
// s_axis side (tlast marks the final byte), and returns one verdict per datagram on the
// m_axis side: status, whether a mapped IPv4 address was found, and its port and address.
// Bytes stream in at one per clock while s_axis_tready is high; each byte is parsed
// straight out of the input register; a verdict is registered as its last byte is taken.
// s_axis_tready only drops when a final byte would produce a new verdict while the
// previous one has not yet been taken. Program the expected transaction ID through the
// cfg port (index 0: bytes 0..3, index 1: bytes 4..11, big-endian) while no datagram is in
// flight. Bytes past MaxDatagramBytes in one datagram are ignored except for their tlast.
module stun_binding_response_parser import sbrp_pkg::*; #(
  parameter int unsigned MaxDatagramBytes = MaxDatagramBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[2:0], address_found[3], mapped_port[19:4], mapped_ip[51:20], zero[55:52]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [31:0] txid_high_q;
  logic [63:0] txid_low_q;

  in_beat_t in_beat, held_beat;
  logic     held_valid;
  logic     take;
  logic     done;
  verdict_t verdict;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txid_high_q <= '0;
      txid_low_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTxidHigh: txid_high_q <= cfg_data_i[31:0];
        CfgTxidLow:  txid_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_beat = '{data: s_axis_tdata, last: s_axis_tlast};

  // a final byte waits while the previous verdict is still pending
  assign take = held_valid && (!held_beat.last || !m_axis_tvalid || m_axis_tready);

  sbrp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .beat_i  (in_beat),
    .valid_o (held_valid),
    .beat_o  (held_beat),
    .take_i  (take)
  );

  sbrp_parse_core #(
    .MaxDatagramBytes (MaxDatagramBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .beat_i      (held_beat),
    .txid_high_i (txid_high_q),
    .txid_low_i  (txid_low_q),
    .done_o      (done),
    .verdict_o   (verdict)
  );

  sbrp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (done),
    .verdict_i (verdict),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .data_o    (m_axis_tdata)
  );

endmodule

// ===== dv/stun_binding_response_parser_tb.sv =====
module stun_binding_response_parser_tb;
  import sbrp_pkg::*;

  typedef logic [7:0] octet_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stun_binding_response_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // parser model state
  logic [31:0]  txid_hi;
  logic [63:0]  txid_lo;
  phase_e       phase;
  logic [4:0]   fpos;
  int unsigned  byte_count;
  logic [15:0]  attr_type;
  logic [15:0]  attr_len;
  logic [16:0]  skip_left;
  status_e      err;
  logic         found;
  logic [15:0]  port_acc;
  logic [31:0]  ip_acc;

  verdict_t     pending_verdicts[$];
  octet_t       dgram[$];
  int           mismatches = 0;
  bit           no_idle = 1'b0;
  int           ready_wait;

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic void clear_datagram();
    phase = PhHeader;
    fpos = '0;
    byte_count = 0;
    attr_type = '0;
    attr_len = '0;
    skip_left = '0;
    err = StOk;
    found = 1'b0;
    port_acc = '0;
    ip_acc = '0;
  endfunction

  function automatic void next_attr();
    phase = PhAttrHdr;
    fpos = '0;
    attr_type = '0;
    attr_len = '0;
  endfunction

  function automatic octet_t txid_byte(int k);
    if (k < 4) return txid_hi[8*(3-k) +: 8];
    return txid_lo[8*(11-k) +: 8];
  endfunction

  function automatic void parse_byte(octet_t b);
    logic [4:0]  p;
    logic [16:0] pad;
    p = fpos;
    case (phase)
      PhHeader: begin
        if (p < 2) begin
          attr_type = {attr_type[7:0], b};
          if (p == 1 && attr_type != BindingSuccess) err = StNotBinding;
        end else if (p >= 4 && p < 8) begin
          ip_acc = {ip_acc[23:0], b};
          if (p == 7) begin
            if (ip_acc != MagicCookie) err = StBadCookie;
            ip_acc = '0;
          end
        end else if (p >= 8 && p < 20) begin
          if (b != txid_byte(p - 8)) err = StIdMismatch;
        end
        fpos = p + 5'd1;
        if (fpos == 5'd20) next_attr();
      end
      PhAttrHdr: begin
        if (p < 2) attr_type = {attr_type[7:0], b};
        else attr_len = {attr_len[7:0], b};
        fpos = p + 5'd1;
        if (p == 3) begin
          if (attr_type == AttrMapped) begin
            if (attr_len != MappedLen) begin
              err = StBadLength;
            end else begin
              phase = PhMapped;
              fpos = '0;
            end
          end else begin
            pad = (attr_len[1:0] == 2'd0) ? 17'd0 : 17'd4 - {15'd0, attr_len[1:0]};
            skip_left = {1'b0, attr_len} + pad;
            if (skip_left == '0) begin
              next_attr();
            end else begin
              phase = PhSkip;
              fpos = '0;
            end
          end
        end
      end
      PhMapped: begin
        if (p == 1) begin
          if (b != FamilyIpv4) err = StNotIpv4;
        end else if (p == 2 || p == 3) begin
          port_acc = {port_acc[7:0], b};
        end else if (p >= 4) begin
          ip_acc = {ip_acc[23:0], b};
        end
        fpos = p + 5'd1;
        if (p >= 7) begin
          found = 1'b1;
          next_attr();
        end
      end
      default: begin
        if (skip_left != '0) skip_left = skip_left - 17'd1;
        if (skip_left == '0) next_attr();
      end
    endcase
  endfunction

  function automatic void predict_verdict(octet_t b, logic last);
    verdict_t v;
    logic     trunc;
    if (byte_count < MaxDatagramBytesDef) begin
      byte_count++;
      if (err == StOk) parse_byte(b);
    end
    if (last) begin
      trunc = phase == PhHeader || phase == PhMapped || (phase == PhAttrHdr && fpos != '0);
      if (err != StOk) v.status = err;
      else if (trunc) v.status = StTruncated;
      else v.status = StOk;
      if (v.status == StOk && found) begin
        v.found = 1'b1;
        v.port = port_acc;
        v.ip = ip_acc;
      end else begin
        v.found = 1'b0;
        v.port = '0;
        v.ip = '0;
      end
      pending_verdicts = {pending_verdicts, v};
      clear_datagram();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 100) $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
    mismatches++;
  endtask

  // result side: random stalls between transactions
  always @(posedge clk_i) begin
    int gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_wait <= draw_gap();
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        gap = draw_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          ready_wait <= gap;
        end
      end
    end else if (ready_wait <= 1) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_wait <= ready_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict", 64'(m_axis_tdata), '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
        if (m_axis_tdata[3] !== want.found)
          report_mismatch("address_found", 64'(m_axis_tdata[3]), 64'(want.found));
        if (m_axis_tdata[19:4] !== want.port)
          report_mismatch("mapped_port", 64'(m_axis_tdata[19:4]), 64'(want.port));
        if (m_axis_tdata[51:20] !== want.ip)
          report_mismatch("mapped_ip", 64'(m_axis_tdata[51:20]), 64'(want.ip));
        if (m_axis_tdata[55:52] !== 4'd0)
          report_mismatch("padding", 64'(m_axis_tdata[55:52]), '0);
      end
    end
  end

  task automatic send_byte(octet_t b, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_verdict(b, last);
  endtask

  task automatic send_datagram();
    int i;
    for (i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // stop sending and let every outstanding verdict drain
  task automatic quiesce();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_verdicts.size() != 0) begin
      report_mismatch("missing verdicts", 64'(pending_verdicts.size()), '0);
      pending_verdicts.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTxidHigh) txid_hi = val[31:0];
    else txid_lo = val;
    @(posedge clk_i);
  endtask

  task automatic set_txid(logic [63:0] hi, logic [63:0] lo);
    quiesce();
    write_reg(CfgTxidHigh, hi);
    write_reg(CfgTxidLow, lo);
  endtask

  function automatic void add8(octet_t v);
    dgram = {dgram, v};
  endfunction

  function automatic void add16(logic [15:0] v);
    add8(v[15:8]);
    add8(v[7:0]);
  endfunction

  function automatic void add32(logic [31:0] v);
    add16(v[31:16]);
    add16(v[15:0]);
  endfunction

  function automatic void add_header(logic [15:0] mtype, logic [31:0] cookie,
                                     logic [31:0] hi, logic [63:0] lo);
    dgram.delete();
    add16(mtype);
    add16(16'($urandom));
    add32(cookie);
    add32(hi);
    add32(lo[63:32]);
    add32(lo[31:0]);
  endfunction

  function automatic void add_good_header();
    add_header(BindingSuccess, MagicCookie, txid_hi, txid_lo);
  endfunction

  function automatic void add_mapped(logic [15:0] len, octet_t fam, logic [15:0] port,
                                     logic [31:0] ip);
    add16(AttrMapped);
    add16(len);
    add8(octet_t'($urandom));
    add8(fam);
    add16(port);
    add32(ip);
  endfunction

  function automatic void add_other(logic [15:0] atype, logic [15:0] len);
    int body;
    body = int'(len) + ((4 - int'(len[1:0])) % 4);
    add16(atype);
    add16(len);
    repeat (body) add8(octet_t'($urandom));
  endfunction

  function automatic void cut_to(int n);
    while (dgram.size() > n) void'(dgram.pop_back());
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_random();
    int          n;
    logic [15:0] mtype;
    logic [15:0] atype;
    logic [15:0] alen;
    logic [31:0] cookie;
    logic [31:0] hi;
    logic [63:0] lo;
    dgram.delete();
    if ($urandom_range(0, 19) < 2) begin
      // noise datagram
      repeat ($urandom_range(1, 40)) add8(octet_t'($urandom));
      return;
    end
    mtype = BindingSuccess;
    if ($urandom_range(0, 19) == 0) mtype = 16'($urandom);
    cookie = MagicCookie;
    if ($urandom_range(0, 19) == 0) cookie ^= 32'd1 << $urandom_range(0, 31);
    hi = txid_hi;
    lo = txid_lo;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) hi ^= 32'd1 << $urandom_range(0, 31);
      else lo ^= 64'd1 << $urandom_range(0, 63);
    end
    add_header(mtype, cookie, hi, lo);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 99) < 55) begin
        alen = ($urandom_range(0, 14) == 0) ? 16'($urandom_range(0, 15)) : MappedLen;
        add_mapped(alen, ($urandom_range(0, 14) == 0) ? octet_t'($urandom) : FamilyIpv4,
                   16'(pick32()), pick32());
      end else begin
        atype = 16'($urandom);
        if (atype == AttrMapped) atype = 16'h8020;
        alen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 60))
                                             : 16'($urandom_range(0, 12));
        add_other(atype, alen);
      end
    end
    // stray bytes of a partial attribute header
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) add8(octet_t'($urandom));
    if ($urandom_range(0, 5) == 0) cut_to($urandom_range(1, dgram.size() - 1));
  endfunction

  task automatic test_reset_txid();
    // registers still hold their reset value
    add_good_header();
    add_mapped(MappedLen, FamilyIpv4, 16'hFFFF, 32'hFFFF_FFFF);
    send_datagram();
  endtask

  task automatic test_header_checks();
    set_txid('1, '1);
    add_good_header();
    send_datagram();
    add_header(16'h0111, MagicCookie, txid_hi, txid_lo);
    send_datagram();
    add_header(16'h0100, MagicCookie, txid_hi, txid_lo);
    send_datagram();
    add_header(BindingSuccess, MagicCookie ^ 32'd1, txid_hi, txid_lo);
    send_datagram();
    add_header(BindingSuccess, MagicCookie, txid_hi, txid_lo ^ 64'd1);
    send_datagram();
    add_header(BindingSuccess, MagicCookie, txid_hi ^ 32'h8000_0000, txid_lo);
    send_datagram();
  endtask

  task automatic test_attribute_walk();
    set_txid({$urandom, $urandom}, {$urandom, $urandom});
    // zero-length and padded skips, then two mapped addresses where the last wins
    add_good_header();
    add_other(16'h8022, 16'd0);
    add_other(16'h0020, 16'd5);
    add_mapped(MappedLen, FamilyIpv4, 16'hFFFF, 32'hFFFF_FFFF);
    add_mapped(MappedLen, FamilyIpv4, 16'h0000, 32'h0000_0000);
    send_datagram();
    add_good_header();
    add_mapped(16'd12, FamilyIpv4, 16'($urandom), $urandom);
    send_datagram();
    add_good_header();
    add_mapped(16'd0, FamilyIpv4, 16'($urandom), $urandom);
    send_datagram();
    add_good_header();
    add_mapped(MappedLen, 8'h02, 16'($urandom), $urandom);
    send_datagram();
    add_good_header();
    add_other(16'hFFFF, 16'd3);
    send_datagram();
  endtask

  task automatic test_truncation();
    set_txid(64'd0, 64'd0);
    dgram.delete();
    add8(8'hFF);
    send_datagram();
    add_good_header();
    cut_to(10);
    send_datagram();
    add_good_header();
    add_other(16'h8028, 16'd4);
    cut_to(22);
    send_datagram();
    add_good_header();
    add_mapped(MappedLen, FamilyIpv4, 16'($urandom), $urandom);
    cut_to(24);
    send_datagram();
    add_good_header();
    add_mapped(MappedLen, FamilyIpv4, 16'($urandom), $urandom);
    cut_to(29);
    send_datagram();
    // ending inside a skipped value or its padding is fine
    add_good_header();
    add_other(16'h8028, 16'd10);
    cut_to(26);
    send_datagram();
    add_good_header();
    add_other(16'h8029, 16'd5);
    cut_to(30);
    send_datagram();
  endtask

  task automatic test_latched_errors();
    set_txid({$urandom, $urandom}, {$urandom, $urandom});
    add_header(16'h0001, MagicCookie ^ 32'h100, txid_hi, txid_lo);
    send_datagram();
    add_header(BindingSuccess, 32'h0, txid_hi, txid_lo);
    cut_to(12);
    send_datagram();
    add_good_header();
    add_mapped(MappedLen, 8'hFF, 16'($urandom), $urandom);
    add16(AttrMapped);
    send_datagram();
    add_good_header();
    add_mapped(16'd7, FamilyIpv4, 16'($urandom), $urandom);
    add_mapped(MappedLen, FamilyIpv4, 16'($urandom), $urandom);
    send_datagram();
  endtask

  task automatic test_oversize();
    set_txid({$urandom, $urandom}, {$urandom, $urandom});
    no_idle = 1'b1;
    // skip ends on the size limit; a bad mapped header after it must be ignored
    add_good_header();
    add_mapped(MappedLen, FamilyIpv4, 16'($urandom), $urandom);
    add_other(16'h8022, 16'(MaxDatagramBytesDef - 36));
    add16(AttrMapped);
    add16(16'h0003);
    repeat (8) add8(octet_t'($urandom));
    send_datagram();
    // datagram ends past the limit while still inside a skipped value
    add_good_header();
    add_mapped(MappedLen, FamilyIpv4, 16'($urandom), $urandom);
    add_other(16'h8023, 16'(MaxDatagramBytesDef - 28));
    cut_to(MaxDatagramBytesDef + 4);
    send_datagram();
    quiesce();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase_idx;
    int sent;
    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      if (phase_idx == 1) set_txid({$urandom, 32'hAAAA_5555}, 64'h5555_AAAA_5555_AAAA);
      else set_txid({$urandom, $urandom}, {$urandom, $urandom});
      no_idle = (phase_idx == 2);
      sent = 0;
      while (sent < 362) begin
        build_random();
        sent += dgram.size();
        send_datagram();
        // now and then the sender holds off until every verdict has come back
        if ($urandom_range(0, 24) == 0) quiesce();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgTxidHigh;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    txid_hi = '0;
    txid_lo = '0;
    clear_datagram();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_txid();
    test_header_checks();
    test_attribute_walk();
    test_truncation();
    test_latched_errors();
    test_oversize();
    test_random_traffic();
    quiesce();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
